// ----- rtl/core/nfcs_pkg.sv -----
// ----------------------------------------------------------------------------
// NAND flash command sequencer package
// Shared types, codes and result-burst helpers for the sequencer.
// ----------------------------------------------------------------------------
package nfcs_pkg;

  // Largest number of bus words that one input word can cause.
  localparam int unsigned MaxRes = 7;

  // Input word kinds.
  typedef enum logic [2:0] {
    KIND_READ  = 3'd0,
    KIND_PROG  = 3'd1,
    KIND_ERASE = 3'd2,
    KIND_READY = 3'd3,
    KIND_FBYTE = 3'd4,
    KIND_HBYTE = 3'd5,
    KIND_ID    = 3'd6,
    KIND_NONE  = 3'd7
  } kind_e;

  // Sequencer modes.
  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_RD_WAIT = 3'd1,
    MODE_RD_DATA = 3'd2,
    MODE_RD_TURN = 3'd3,
    MODE_PG_DATA = 3'd4,
    MODE_PG_WAIT = 3'd5,
    MODE_ER_WAIT = 3'd6,
    MODE_ID_DATA = 3'd7
  } mode_e;

  // Result word types.
  typedef enum logic [2:0] {
    CYC_CMD   = 3'd0,
    CYC_ADDR  = 3'd1,
    CYC_WDATA = 3'd2,
    CYC_HOST  = 3'd3,
    CYC_ERR   = 3'd4,
    CYC_DONE  = 3'd5
  } cycle_e;

  // NAND command codes.
  localparam logic [7:0] CmdRead1  = 8'h00;
  localparam logic [7:0] CmdRead2  = 8'h30;
  localparam logic [7:0] CmdProg1  = 8'h80;
  localparam logic [7:0] CmdProg2  = 8'h10;
  localparam logic [7:0] CmdErase1 = 8'h60;
  localparam logic [7:0] CmdErase2 = 8'hD0;
  localparam logic [7:0] CmdReadId = 8'h90;
  localparam logic [7:0] AddrZero  = 8'h00;

  // Error codes.
  localparam logic [7:0] ErrAddrAlign = 8'd1;
  localparam logic [7:0] ErrLenAlign  = 8'd2;
  localparam logic [7:0] ErrBusy      = 8'd3;

  // One result word.
  typedef struct packed {
    cycle_e     cycle_type;
    logic [7:0] value;
    logic       cs;
  } res_t;

  // All result words of one input word; cnt of zero means empty.
  typedef struct packed {
    res_t [MaxRes-1:0] ent;
    logic [2:0]        cnt;
  } burst_t;

  // Append one result word to a burst.
  function automatic burst_t push(burst_t b, cycle_e t, logic [7:0] v, logic cs);
    burst_t r;
    r = b;
    r.ent[b.cnt] = res_t'{cycle_type: t, value: v, cs: cs};
    r.cnt = b.cnt + 3'd1;
    return r;
  endfunction

  // Append the three row address bytes.
  function automatic burst_t push_row(burst_t b, logic [23:0] page);
    burst_t r;
    r = push(b, CYC_ADDR, page[7:0], 1'b1);
    r = push(r, CYC_ADDR, page[15:8], 1'b1);
    r = push(r, CYC_ADDR, page[23:16], 1'b1);
    return r;
  endfunction

  // Append two column bytes and three row bytes.
  function automatic burst_t push_addr(burst_t b, logic [15:0] col, logic [23:0] page);
    burst_t r;
    r = push(b, CYC_ADDR, col[7:0], 1'b1);
    r = push(r, CYC_ADDR, col[15:8], 1'b1);
    r = push_row(r, page);
    return r;
  endfunction

  // Append one block erase sequence.
  function automatic burst_t push_erase(burst_t b, logic [23:0] page);
    burst_t r;
    r = push(b, CYC_CMD, CmdErase1, 1'b1);
    r = push_row(r, page);
    r = push(r, CYC_CMD, CmdErase2, 1'b1);
    return r;
  endfunction

endpackage

// ----- rtl/core/nfcs_core.sv -----
// ----------------------------------------------------------------------------
// NAND flash command sequencer core
// Holds the operation state, decodes each accepted word in the cycle it is
// accepted and registers the resulting burst of bus words.
// ----------------------------------------------------------------------------
module nfcs_core #(
  parameter int unsigned PAGE_BYTES  = 2048,
  parameter int unsigned BLOCK_BYTES = 131072,
  parameter int unsigned ID_BYTES    = 5
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [2:0]          kind_i,
  input  logic [31:0]         byte_addr_i,
  input  logic [31:0]         length_i,
  input  logic [7:0]          data_i,
  input  logic                take_i,
  output nfcs_pkg::burst_t    burst_o
);

  localparam int unsigned PageW = $clog2(PAGE_BYTES);
  localparam int unsigned BlkW  = $clog2(BLOCK_BYTES);
  localparam int unsigned ColW  = PageW + 1;
  localparam logic [23:0] PageStep  = 24'(BLOCK_BYTES / PAGE_BYTES);
  localparam logic [ColW-1:0] PageEnd = ColW'(PAGE_BYTES);

  nfcs_pkg::mode_e    mode_q, mode_d;
  logic [23:0]        page_q, page_d;
  logic [ColW-1:0]    col_q, col_d;
  logic [31:0]        left_q, left_d;
  nfcs_pkg::burst_t   burst_q, burst_d;
  nfcs_pkg::burst_t   bld;

  nfcs_pkg::kind_e    kind;
  logic               accept;
  logic [23:0]        req_page, page_inc, page_blk;
  logic [ColW-1:0]    req_col, col_inc;
  logic [31:0]        left_dec, left_blk;
  logic               len_zero, addr_blk_ok, len_blk_ok, col_end;
  logic [15:0]        col16;

  // Accept when the burst register is empty or is handed on this cycle.
  assign in_stall_o = (burst_q.cnt != 3'd0) && !take_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign kind       = nfcs_pkg::kind_e'(kind_i);

  // Shared arithmetic on the request and the current state.
  assign req_page    = 24'(byte_addr_i >> PageW);
  assign req_col     = ColW'(byte_addr_i[PageW-1:0]);
  assign page_inc    = page_q + 24'd1;
  assign page_blk    = page_q + PageStep;
  assign col_inc     = col_q + ColW'(1);
  assign col_end     = col_inc >= PageEnd;
  assign left_dec    = left_q - 32'd1;
  assign left_blk    = left_q - 32'(BLOCK_BYTES);
  assign len_zero    = length_i == 32'd0;
  assign addr_blk_ok = byte_addr_i[BlkW-1:0] == '0;
  assign len_blk_ok  = length_i[BlkW-1:0] == '0;
  assign col16       = 16'(col_q);

  // Next state of the operation.
  always_comb begin
    mode_d = mode_q;
    page_d = page_q;
    col_d  = col_q;
    left_d = left_q;
    unique case (kind)
      nfcs_pkg::KIND_READ: begin
        if (mode_q == nfcs_pkg::MODE_IDLE && !len_zero) begin
          page_d = req_page;
          col_d  = req_col;
          left_d = length_i;
          mode_d = nfcs_pkg::MODE_RD_WAIT;
        end
      end
      nfcs_pkg::KIND_PROG: begin
        if (mode_q == nfcs_pkg::MODE_IDLE) begin
          page_d = req_page;
          col_d  = req_col;
          left_d = length_i;
          mode_d = len_zero ? nfcs_pkg::MODE_PG_WAIT : nfcs_pkg::MODE_PG_DATA;
        end
      end
      nfcs_pkg::KIND_ERASE: begin
        if (mode_q == nfcs_pkg::MODE_IDLE && addr_blk_ok && len_blk_ok && !len_zero) begin
          page_d = req_page;
          left_d = length_i;
          mode_d = nfcs_pkg::MODE_ER_WAIT;
        end
      end
      nfcs_pkg::KIND_ID: begin
        if (mode_q == nfcs_pkg::MODE_IDLE) begin
          left_d = 32'(ID_BYTES);
          mode_d = nfcs_pkg::MODE_ID_DATA;
        end
      end
      nfcs_pkg::KIND_READY: begin
        unique case (mode_q)
          nfcs_pkg::MODE_RD_WAIT: mode_d = nfcs_pkg::MODE_RD_DATA;
          nfcs_pkg::MODE_RD_TURN: mode_d = nfcs_pkg::MODE_RD_WAIT;
          nfcs_pkg::MODE_PG_WAIT: begin
            if (left_q == 32'd0) begin
              mode_d = nfcs_pkg::MODE_IDLE;
            end else begin
              col_d  = '0;
              page_d = page_inc;
              mode_d = nfcs_pkg::MODE_PG_DATA;
            end
          end
          nfcs_pkg::MODE_ER_WAIT: begin
            left_d = left_blk;
            if (left_blk == 32'd0) begin
              mode_d = nfcs_pkg::MODE_IDLE;
            end else begin
              page_d = page_blk;
            end
          end
          default: ;
        endcase
      end
      nfcs_pkg::KIND_FBYTE: begin
        if (mode_q == nfcs_pkg::MODE_RD_DATA) begin
          col_d  = col_inc;
          left_d = left_dec;
          if (left_dec == 32'd0) begin
            mode_d = nfcs_pkg::MODE_IDLE;
          end else if (col_end) begin
            col_d  = '0;
            page_d = page_inc;
            mode_d = nfcs_pkg::MODE_RD_TURN;
          end
        end else if (mode_q == nfcs_pkg::MODE_ID_DATA) begin
          left_d = left_dec;
          if (left_dec == 32'd0) begin
            mode_d = nfcs_pkg::MODE_IDLE;
          end
        end
      end
      nfcs_pkg::KIND_HBYTE: begin
        if (mode_q == nfcs_pkg::MODE_PG_DATA) begin
          col_d  = col_inc;
          left_d = left_dec;
          if (left_dec == 32'd0 || col_end) begin
            mode_d = nfcs_pkg::MODE_PG_WAIT;
          end
        end
      end
      nfcs_pkg::KIND_NONE: ;
      default: ;
    endcase
  end

  // Bus words caused by the current input word.
  always_comb begin
    bld = '0;
    unique case (kind)
      nfcs_pkg::KIND_READ, nfcs_pkg::KIND_PROG, nfcs_pkg::KIND_ERASE,
      nfcs_pkg::KIND_ID: begin
        if (mode_q != nfcs_pkg::MODE_IDLE) begin
          bld = nfcs_pkg::push(bld, nfcs_pkg::CYC_ERR, nfcs_pkg::ErrBusy, 1'b1);
        end else if (kind == nfcs_pkg::KIND_READ) begin
          if (len_zero) begin
            bld = nfcs_pkg::push(bld, nfcs_pkg::CYC_DONE, 8'd0, 1'b0);
          end else begin
            bld = nfcs_pkg::push(bld, nfcs_pkg::CYC_CMD, nfcs_pkg::CmdRead1, 1'b1);
            bld = nfcs_pkg::push_addr(bld, 16'(req_col), req_page);
            bld = nfcs_pkg::push(bld, nfcs_pkg::CYC_CMD, nfcs_pkg::CmdRead2, 1'b1);
          end
        end else if (kind == nfcs_pkg::KIND_PROG) begin
          bld = nfcs_pkg::push(bld, nfcs_pkg::CYC_CMD, nfcs_pkg::CmdProg1, 1'b1);
          bld = nfcs_pkg::push_addr(bld, 16'(req_col), req_page);
          if (len_zero) begin
            bld = nfcs_pkg::push(bld, nfcs_pkg::CYC_CMD, nfcs_pkg::CmdProg2, 1'b1);
          end
        end else if (kind == nfcs_pkg::KIND_ERASE) begin
          if (!addr_blk_ok) begin
            bld = nfcs_pkg::push(bld, nfcs_pkg::CYC_ERR, nfcs_pkg::ErrAddrAlign, 1'b0);
          end else if (!len_blk_ok) begin
            bld = nfcs_pkg::push(bld, nfcs_pkg::CYC_ERR, nfcs_pkg::ErrLenAlign, 1'b0);
          end else if (len_zero) begin
            bld = nfcs_pkg::push(bld, nfcs_pkg::CYC_DONE, 8'd0, 1'b0);
          end else begin
            bld = nfcs_pkg::push_erase(bld, req_page);
          end
        end else begin
          bld = nfcs_pkg::push(bld, nfcs_pkg::CYC_CMD, nfcs_pkg::CmdReadId, 1'b1);
          bld = nfcs_pkg::push(bld, nfcs_pkg::CYC_ADDR, nfcs_pkg::AddrZero, 1'b1);
        end
      end
      nfcs_pkg::KIND_READY: begin
        unique case (mode_q)
          nfcs_pkg::MODE_RD_TURN: begin
            bld = nfcs_pkg::push(bld, nfcs_pkg::CYC_CMD, nfcs_pkg::CmdRead1, 1'b1);
            bld = nfcs_pkg::push_addr(bld, col16, page_q);
            bld = nfcs_pkg::push(bld, nfcs_pkg::CYC_CMD, nfcs_pkg::CmdRead2, 1'b1);
          end
          nfcs_pkg::MODE_PG_WAIT: begin
            if (left_q == 32'd0) begin
              bld = nfcs_pkg::push(bld, nfcs_pkg::CYC_DONE, 8'd0, 1'b0);
            end else begin
              bld = nfcs_pkg::push(bld, nfcs_pkg::CYC_CMD, nfcs_pkg::CmdProg1, 1'b1);
              bld = nfcs_pkg::push_addr(bld, 16'd0, page_inc);
            end
          end
          nfcs_pkg::MODE_ER_WAIT: begin
            if (left_blk == 32'd0) begin
              bld = nfcs_pkg::push(bld, nfcs_pkg::CYC_DONE, 8'd0, 1'b0);
            end else begin
              bld = nfcs_pkg::push_erase(bld, page_blk);
            end
          end
          default: ;
        endcase
      end
      nfcs_pkg::KIND_FBYTE: begin
        if (mode_q == nfcs_pkg::MODE_RD_DATA || mode_q == nfcs_pkg::MODE_ID_DATA) begin
          bld = nfcs_pkg::push(bld, nfcs_pkg::CYC_HOST, data_i, 1'b1);
          if (left_dec == 32'd0) begin
            bld = nfcs_pkg::push(bld, nfcs_pkg::CYC_DONE, 8'd0, 1'b0);
          end
        end
      end
      nfcs_pkg::KIND_HBYTE: begin
        if (mode_q == nfcs_pkg::MODE_PG_DATA) begin
          bld = nfcs_pkg::push(bld, nfcs_pkg::CYC_WDATA, data_i, 1'b1);
          if (left_dec == 32'd0 || col_end) begin
            bld = nfcs_pkg::push(bld, nfcs_pkg::CYC_CMD, nfcs_pkg::CmdProg2, 1'b1);
          end
        end
      end
      nfcs_pkg::KIND_NONE: ;
      default: ;
    endcase
  end

  // Burst register: loaded on accept, emptied when handed on.
  always_comb begin
    burst_d = burst_q;
    if (accept) begin
      burst_d = bld;
    end else if (take_i) begin
      burst_d.cnt = 3'd0;
    end
  end

  // State and burst registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= nfcs_pkg::MODE_IDLE;
      page_q  <= '0;
      col_q   <= '0;
      left_q  <= '0;
      burst_q <= '0;
    end else begin
      burst_q <= burst_d;
      if (accept) begin
        mode_q <= mode_d;
        page_q <= page_d;
        col_q  <= col_d;
        left_q <= left_d;
      end
    end
  end

  assign burst_o = burst_q;

endmodule

// ----- rtl/core/nfcs_emit.sv -----
// ----------------------------------------------------------------------------
// NAND flash command sequencer result serializer
// Takes one burst at a time and sends its words out one per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
module nfcs_emit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  nfcs_pkg::burst_t  burst_i,
  output logic              take_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [2:0]        cycle_type_o,
  output logic [7:0]        value_o,
  output logic              chip_select_o,
  output logic              last_o
);

  nfcs_pkg::burst_t  buf_q, buf_d;
  logic [2:0]        idx_q, idx_d;
  nfcs_pkg::res_t    cur;
  logic              busy, fire, fin;

  assign busy = buf_q.cnt != 3'd0;
  assign cur  = buf_q.ent[idx_q];
  assign fire = busy && !out_stall_i;
  assign fin  = fire && (idx_q == buf_q.cnt - 3'd1);

  // A new burst may enter when the buffer is empty or its final word leaves.
  assign take_o = (!busy || fin) && (burst_i.cnt != 3'd0);

  // Next buffer contents and word index.
  always_comb begin
    buf_d = buf_q;
    idx_d = idx_q;
    if (take_o) begin
      buf_d = burst_i;
      idx_d = 3'd0;
    end else if (fin) begin
      buf_d.cnt = 3'd0;
      idx_d     = 3'd0;
    end else if (fire) begin
      idx_d = idx_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_q <= '0;
      idx_q <= '0;
    end else begin
      buf_q <= buf_d;
      idx_q <= idx_d;
    end
  end

  // Output word.
  assign out_valid_o   = busy;
  assign cycle_type_o  = cur.cycle_type;
  assign value_o       = cur.value;
  assign chip_select_o = cur.cs;
  assign last_o        = idx_q == buf_q.cnt - 3'd1;

endmodule

// ----- rtl/core/nand_flash_command_sequencer_top.sv -----
// ----------------------------------------------------------------------------
// NAND flash command sequencer
// Host-side sequencer for large-page NAND: turns read, program, erase and
// read-ID requests plus flash and host events into bus words.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake                Payload
//   in       input      in_valid_i / in_stall_o  kind, byte_addr, length, data
//   out      output     out_valid_o / out_stall_i cycle_type, value, chip_select,
//                                                last
//
// An input word is decoded in the cycle it is accepted and its bus words, up
// to seven, are registered as one burst. The serializer sends one word per
// cycle while the output is not stalled; a new input word is taken once the
// pending burst, if any, is handed to the serializer. One burst waits while
// the previous one drains. Reset is asynchronous and active low; it returns
// the sequencer to idle with both burst stages empty.
//
module nand_flash_command_sequencer_top #(
  parameter int unsigned PAGE_BYTES  = 2048,
  parameter int unsigned BLOCK_BYTES = 131072,
  parameter int unsigned ID_BYTES    = 5
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  kind_i,
  input  logic [31:0] byte_addr_i,
  input  logic [31:0] length_i,
  input  logic [7:0]  data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  cycle_type_o,
  output logic [7:0]  value_o,
  output logic        chip_select_o,
  output logic        last_o
);

  nfcs_pkg::burst_t burst;
  logic             take;

  // Decode and state.
  nfcs_core #(
    .PAGE_BYTES  (PAGE_BYTES),
    .BLOCK_BYTES (BLOCK_BYTES),
    .ID_BYTES    (ID_BYTES)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .kind_i      (kind_i),
    .byte_addr_i (byte_addr_i),
    .length_i    (length_i),
    .data_i      (data_i),
    .take_i      (take),
    .burst_o     (burst)
  );

  // Word-by-word output.
  nfcs_emit u_emit (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .burst_i       (burst),
    .take_o        (take),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .cycle_type_o  (cycle_type_o),
    .value_o       (value_o),
    .chip_select_o (chip_select_o),
    .last_o        (last_o)
  );

endmodule

// ----- verif/tb_nand_flash_command_sequencer_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// NAND flash command sequencer testbench
// Drives read, program, erase and read-ID sequences with flash and host events
// into the sequencer, predicts every bus word it should emit, and checks each
// emitted word in order with random idle cycles on both channels.
// ----------------------------------------------------------------------------
module tb_nand_flash_command_sequencer_top;

  localparam int unsigned PgBytes    = 2048;
  localparam int unsigned BlkBytes   = 131072;
  localparam int unsigned IdBytes    = 5;
  localparam int unsigned BlkPages   = BlkBytes / PgBytes;
  localparam int unsigned QuietLimit = 2000;
  localparam int unsigned RandItems  = 70;

  // One input word waiting to be sent, with its lead-in idle cycles.
  typedef struct {
    nfcs_pkg::kind_e kind;
    logic [31:0]     addr;
    logic [31:0]     len;
    logic [7:0]      data;
    int unsigned     gap;
    bit              drain;
  } req_word_t;

  // One expected bus word.
  typedef struct {
    nfcs_pkg::cycle_e ctype;
    logic [7:0]       val;
    logic             cs;
    logic             last;
  } bus_word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [2:0]  kind_i = nfcs_pkg::KIND_NONE;
  logic [31:0] byte_addr_i = '0;
  logic [31:0] length_i = '0;
  logic [7:0]  data_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [2:0]  cycle_type_o;
  logic [7:0]  value_o;
  logic        chip_select_o;
  logic        last_o;

  req_word_t   req_q[$];
  bus_word_t   bus_words_q[$];
  bus_word_t   burst_q[$];

  // Shadow of the sequencer state.
  nfcs_pkg::mode_e seq_mode = nfcs_pkg::MODE_IDLE;
  logic [23:0]     seq_page = '0;
  logic [15:0]     seq_col = '0;
  logic [31:0]     seq_left = '0;

  int unsigned n_pred = 0;
  int unsigned n_seen = 0;
  int unsigned n_errors = 0;
  int unsigned n_rand = 0;
  int unsigned hold_cnt = 0;
  int unsigned stall_left = 0;
  int unsigned quiet_cycles = 0;
  bit          calm_tx = 1'b0;
  bit          calm_rx = 1'b0;
  bit          noisy = 1'b0;
  bit          drain_next = 1'b0;

  nand_flash_command_sequencer_top #(
    .PAGE_BYTES (PgBytes),
    .BLOCK_BYTES(BlkBytes),
    .ID_BYTES   (IdBytes)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .kind_i       (kind_i),
    .byte_addr_i  (byte_addr_i),
    .length_i     (length_i),
    .data_i       (data_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .cycle_type_o (cycle_type_o),
    .value_o      (value_o),
    .chip_select_o(chip_select_o),
    .last_o       (last_o)
  );

  // Clock and a single reset pulse.
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
  end

  // Idle cycles before the next word; none during a calm stretch.
  function automatic int unsigned draw_wait(bit calm);
    return calm ? 0 : $urandom_range(0, 8);
  endfunction

  // ---------------------------------------------------------------------------
  // Bus word prediction
  // ---------------------------------------------------------------------------

  task automatic put_word(nfcs_pkg::cycle_e t, logic [7:0] v, logic cs);
    bus_word_t w;
    w.ctype = t;
    w.val   = v;
    w.cs    = cs;
    w.last  = 1'b0;
    burst_q.push_back(w);
  endtask

  task automatic put_row();
    put_word(nfcs_pkg::CYC_ADDR, seq_page[7:0], 1'b1);
    put_word(nfcs_pkg::CYC_ADDR, seq_page[15:8], 1'b1);
    put_word(nfcs_pkg::CYC_ADDR, seq_page[23:16], 1'b1);
  endtask

  task automatic put_addr();
    put_word(nfcs_pkg::CYC_ADDR, seq_col[7:0], 1'b1);
    put_word(nfcs_pkg::CYC_ADDR, seq_col[15:8], 1'b1);
    put_row();
  endtask

  task automatic put_erase();
    put_word(nfcs_pkg::CYC_CMD, nfcs_pkg::CmdErase1, 1'b1);
    put_row();
    put_word(nfcs_pkg::CYC_CMD, nfcs_pkg::CmdErase2, 1'b1);
  endtask

  // Advance the shadow state by one accepted word and queue its bus words.
  task automatic predict_bus_words(nfcs_pkg::kind_e k, logic [31:0] a, logic [31:0] l,
                                   logic [7:0] d);
    bus_word_t w;
    burst_q.delete();
    case (k)
      nfcs_pkg::KIND_READ, nfcs_pkg::KIND_PROG, nfcs_pkg::KIND_ERASE,
      nfcs_pkg::KIND_ID: begin
        if (seq_mode != nfcs_pkg::MODE_IDLE) begin
          put_word(nfcs_pkg::CYC_ERR, nfcs_pkg::ErrBusy, 1'b1);
        end else if (k == nfcs_pkg::KIND_READ) begin
          if (l == 0) begin
            put_word(nfcs_pkg::CYC_DONE, 8'h00, 1'b0);
          end else begin
            seq_page = 24'(a / PgBytes);
            seq_col  = 16'(a % PgBytes);
            seq_left = l;
            put_word(nfcs_pkg::CYC_CMD, nfcs_pkg::CmdRead1, 1'b1);
            put_addr();
            put_word(nfcs_pkg::CYC_CMD, nfcs_pkg::CmdRead2, 1'b1);
            seq_mode = nfcs_pkg::MODE_RD_WAIT;
          end
        end else if (k == nfcs_pkg::KIND_PROG) begin
          seq_page = 24'(a / PgBytes);
          seq_col  = 16'(a % PgBytes);
          seq_left = l;
          put_word(nfcs_pkg::CYC_CMD, nfcs_pkg::CmdProg1, 1'b1);
          put_addr();
          if (l == 0) begin
            put_word(nfcs_pkg::CYC_CMD, nfcs_pkg::CmdProg2, 1'b1);
            seq_mode = nfcs_pkg::MODE_PG_WAIT;
          end else begin
            seq_mode = nfcs_pkg::MODE_PG_DATA;
          end
        end else if (k == nfcs_pkg::KIND_ERASE) begin
          if (a % BlkBytes != 0) begin
            put_word(nfcs_pkg::CYC_ERR, nfcs_pkg::ErrAddrAlign, 1'b0);
          end else if (l % BlkBytes != 0) begin
            put_word(nfcs_pkg::CYC_ERR, nfcs_pkg::ErrLenAlign, 1'b0);
          end else if (l == 0) begin
            put_word(nfcs_pkg::CYC_DONE, 8'h00, 1'b0);
          end else begin
            seq_page = 24'(a / PgBytes);
            seq_left = l;
            put_erase();
            seq_mode = nfcs_pkg::MODE_ER_WAIT;
          end
        end else begin
          seq_left = IdBytes;
          put_word(nfcs_pkg::CYC_CMD, nfcs_pkg::CmdReadId, 1'b1);
          put_word(nfcs_pkg::CYC_ADDR, nfcs_pkg::AddrZero, 1'b1);
          seq_mode = nfcs_pkg::MODE_ID_DATA;
        end
      end
      nfcs_pkg::KIND_READY: begin
        case (seq_mode)
          nfcs_pkg::MODE_RD_WAIT: seq_mode = nfcs_pkg::MODE_RD_DATA;
          nfcs_pkg::MODE_RD_TURN: begin
            put_word(nfcs_pkg::CYC_CMD, nfcs_pkg::CmdRead1, 1'b1);
            put_addr();
            put_word(nfcs_pkg::CYC_CMD, nfcs_pkg::CmdRead2, 1'b1);
            seq_mode = nfcs_pkg::MODE_RD_WAIT;
          end
          nfcs_pkg::MODE_PG_WAIT: begin
            if (seq_left == 0) begin
              put_word(nfcs_pkg::CYC_DONE, 8'h00, 1'b0);
              seq_mode = nfcs_pkg::MODE_IDLE;
            end else begin
              seq_col  = '0;
              seq_page = seq_page + 24'd1;
              put_word(nfcs_pkg::CYC_CMD, nfcs_pkg::CmdProg1, 1'b1);
              put_addr();
              seq_mode = nfcs_pkg::MODE_PG_DATA;
            end
          end
          nfcs_pkg::MODE_ER_WAIT: begin
            seq_left = seq_left - BlkBytes;
            if (seq_left == 0) begin
              put_word(nfcs_pkg::CYC_DONE, 8'h00, 1'b0);
              seq_mode = nfcs_pkg::MODE_IDLE;
            end else begin
              seq_page = seq_page + 24'(BlkPages);
              put_erase();
            end
          end
          default: ;
        endcase
      end
      nfcs_pkg::KIND_FBYTE: begin
        if (seq_mode == nfcs_pkg::MODE_RD_DATA) begin
          put_word(nfcs_pkg::CYC_HOST, d, 1'b1);
          seq_col  = seq_col + 16'd1;
          seq_left = seq_left - 32'd1;
          if (seq_left == 0) begin
            put_word(nfcs_pkg::CYC_DONE, 8'h00, 1'b0);
            seq_mode = nfcs_pkg::MODE_IDLE;
          end else if (seq_col >= PgBytes) begin
            seq_col  = '0;
            seq_page = seq_page + 24'd1;
            seq_mode = nfcs_pkg::MODE_RD_TURN;
          end
        end else if (seq_mode == nfcs_pkg::MODE_ID_DATA) begin
          put_word(nfcs_pkg::CYC_HOST, d, 1'b1);
          seq_left = seq_left - 32'd1;
          if (seq_left == 0) begin
            put_word(nfcs_pkg::CYC_DONE, 8'h00, 1'b0);
            seq_mode = nfcs_pkg::MODE_IDLE;
          end
        end
      end
      nfcs_pkg::KIND_HBYTE: begin
        if (seq_mode == nfcs_pkg::MODE_PG_DATA) begin
          put_word(nfcs_pkg::CYC_WDATA, d, 1'b1);
          seq_col  = seq_col + 16'd1;
          seq_left = seq_left - 32'd1;
          if (seq_left == 0 || seq_col >= PgBytes) begin
            put_word(nfcs_pkg::CYC_CMD, nfcs_pkg::CmdProg2, 1'b1);
            seq_mode = nfcs_pkg::MODE_PG_WAIT;
          end
        end
      end
      default: ;
    endcase
    // The final word of the burst carries the last flag.
    if (burst_q.size() != 0) begin
      w = burst_q.pop_back();
      w.last = 1'b1;
      burst_q.push_back(w);
    end
    foreach (burst_q[i]) bus_words_q.push_back(burst_q[i]);
    n_pred += burst_q.size();
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus generation
  // ---------------------------------------------------------------------------

  task automatic add_item(nfcs_pkg::kind_e k, logic [31:0] a = '0, logic [31:0] l = '0,
                          logic [7:0] d = '0, bit live = 1'b1);
    req_word_t r;
    if ($urandom_range(0, 15) == 0) calm_tx = ~calm_tx;
    r.kind  = k;
    r.addr  = a;
    r.len   = l;
    r.data  = d;
    r.gap   = draw_wait(calm_tx);
    r.drain = drain_next;
    drain_next = 1'b0;
    req_q.push_back(r);
    if (live) n_rand++;
  endtask

  // Occasionally slip a request or an empty word into a running operation.
  task automatic maybe_noise();
    nfcs_pkg::kind_e k;
    if (noisy && $urandom_range(0, 7) == 0) begin
      if ($urandom_range(0, 2) == 0) begin
        add_item(nfcs_pkg::KIND_NONE, $urandom, $urandom, 8'($urandom), 1'b0);
      end else begin
        case ($urandom_range(0, 3))
          0: k = nfcs_pkg::KIND_READ;
          1: k = nfcs_pkg::KIND_PROG;
          2: k = nfcs_pkg::KIND_ERASE;
          default: k = nfcs_pkg::KIND_ID;
        endcase
        add_item(k, $urandom, $urandom, 8'($urandom));
      end
    end
  endtask

  // Address with the column often close to the page end.
  function automatic logic [31:0] rand_addr();
    logic [31:0] a;
    a = $urandom;
    if ($urandom_range(0, 1) == 0) a[10:0] = 11'h7FF - 11'($urandom_range(0, 3));
    return a;
  endfunction

  task automatic gen_read(logic [31:0] a, logic [31:0] l);
    int unsigned col;
    int unsigned left;
    add_item(nfcs_pkg::KIND_READ, a, l);
    if (l != 0) begin
      col  = a % PgBytes;
      left = l;
      add_item(nfcs_pkg::KIND_READY);
      while (left != 0) begin
        maybe_noise();
        add_item(nfcs_pkg::KIND_FBYTE, $urandom, $urandom, 8'($urandom));
        col++;
        left--;
        // Page turn: one ready for the new address, one for the data.
        if (left != 0 && col == PgBytes) begin
          col = 0;
          add_item(nfcs_pkg::KIND_READY);
          maybe_noise();
          add_item(nfcs_pkg::KIND_READY);
        end
      end
    end
  endtask

  task automatic gen_prog(logic [31:0] a, logic [31:0] l);
    int unsigned col;
    int unsigned left;
    add_item(nfcs_pkg::KIND_PROG, a, l);
    col  = a % PgBytes;
    left = l;
    if (l == 0) add_item(nfcs_pkg::KIND_READY);
    while (left != 0) begin
      maybe_noise();
      add_item(nfcs_pkg::KIND_HBYTE, $urandom, $urandom, 8'($urandom));
      col++;
      left--;
      if (left == 0 || col == PgBytes) begin
        col = 0;
        maybe_noise();
        add_item(nfcs_pkg::KIND_READY);
      end
    end
  endtask

  task automatic gen_erase(logic [31:0] a, int unsigned blocks);
    add_item(nfcs_pkg::KIND_ERASE, a, blocks * BlkBytes);
    repeat (blocks) begin
      maybe_noise();
      add_item(nfcs_pkg::KIND_READY);
    end
  endtask

  task automatic gen_id();
    add_item(nfcs_pkg::KIND_ID, $urandom, $urandom, 8'($urandom));
    repeat (IdBytes) begin
      maybe_noise();
      add_item(nfcs_pkg::KIND_FBYTE, $urandom, $urandom, 8'($urandom));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: presents queued words after their idle cycles
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    req_word_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      hold_cnt   <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        predict_bus_words(nfcs_pkg::kind_e'(kind_i), byte_addr_i, length_i, data_i);
      end
      if (!in_valid_i || !in_stall_o) begin
        if (req_q.size() != 0 && hold_cnt >= req_q[0].gap &&
            (!req_q[0].drain || n_seen == n_pred)) begin
          nxt = req_q.pop_front();
          kind_i      <= nxt.kind;
          byte_addr_i <= nxt.addr;
          length_i    <= nxt.len;
          data_i      <= nxt.data;
          in_valid_i  <= 1'b1;
          hold_cnt    <= 0;
        end else begin
          in_valid_i <= 1'b0;
          if (req_q.size() != 0) hold_cnt <= hold_cnt + 1;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks each bus word and stalls the output at random
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    bus_word_t   want;
    int unsigned d;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left  <= 0;
    end else if (out_valid_o && !out_stall_i) begin
      n_seen <= n_seen + 1;
      if (bus_words_q.size() == 0) begin
        $display("%0t: expected none, actual type %0d value %02h cs %0b last %0b",
                 $time, cycle_type_o, value_o, chip_select_o, last_o);
        n_errors++;
      end else begin
        want = bus_words_q.pop_front();
        if (cycle_type_o !== want.ctype || value_o !== want.val ||
            chip_select_o !== want.cs || last_o !== want.last) begin
          $display("%0t: expected type/value/cs/last %0d/%02h/%0b/%0b, actual %0d/%02h/%0b/%0b",
                   $time, want.ctype, want.val, want.cs, want.last,
                   cycle_type_o, value_o, chip_select_o, last_o);
          n_errors++;
        end
      end
      if ($urandom_range(0, 15) == 0) calm_rx = ~calm_rx;
      d = draw_wait(calm_rx);
      out_stall_i <= (d != 0);
      stall_left  <= (d != 0) ? d - 1 : 0;
    end else if (stall_left != 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= stall_left - 1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Watchdog on cycles in which neither channel moves a word.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [31:0] a;
    // Stray events while idle are ignored.
    add_item(nfcs_pkg::KIND_READY, '0, '0, '0, 1'b0);
    add_item(nfcs_pkg::KIND_FBYTE, '0, '0, 8'hFF, 1'b0);
    add_item(nfcs_pkg::KIND_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 1'b0);
    // Zero-length read and erase finish at once; misaligned erases fail.
    add_item(nfcs_pkg::KIND_READ, 32'hFFFF_FFFF, '0);
    add_item(nfcs_pkg::KIND_ERASE, '0, '0);
    add_item(nfcs_pkg::KIND_ERASE, 32'h0000_0001, '0);
    add_item(nfcs_pkg::KIND_ERASE, '0, 32'hFFFF_FFFF);
    // Zero-length program at the top address still sends the commands.
    gen_prog(32'hFFFF_FFFF, '0);
    // Read ID after a full drain, with a request arriving while busy.
    drain_next = 1'b1;
    add_item(nfcs_pkg::KIND_ID);
    add_item(nfcs_pkg::KIND_READ, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_item(nfcs_pkg::KIND_FBYTE, '0, '0, 8'h00);
    add_item(nfcs_pkg::KIND_FBYTE, '0, '0, 8'hFF);
    repeat (IdBytes - 2) add_item(nfcs_pkg::KIND_FBYTE, '0, '0, 8'($urandom));
    // Read and program across a page boundary, erase of the top block.
    gen_read(32'h0000_07FF, 32'd2);
    gen_prog(32'h0000_07FF, 32'd2);
    gen_erase(32'hFFFE_0000, 1);

    // Random part: mostly complete operations with noise mixed in.
    noisy      = 1'b1;
    n_rand     = 0;
    drain_next = 1'b1;
    while (n_rand < RandItems) begin
      case ($urandom_range(0, 9))
        0, 1, 2: gen_read(rand_addr(), $urandom_range(0, 6));
        3, 4, 5: gen_prog(rand_addr(), $urandom_range(0, 6));
        6: begin
          a = $urandom;
          a[16:0] = '0;
          gen_erase(a, $urandom_range(1, 3));
        end
        7: gen_id();
        8: begin
          // Misaligned erase requests.
          a = $urandom;
          if ($urandom_range(0, 1) == 0) begin
            add_item(nfcs_pkg::KIND_ERASE, a | 32'h1, $urandom);
          end else begin
            a[16:0] = '0;
            add_item(nfcs_pkg::KIND_ERASE, a, $urandom | 32'h1);
          end
        end
        default: begin
          case ($urandom_range(0, 3))
            0: add_item(nfcs_pkg::KIND_READY, $urandom, $urandom, 8'($urandom), 1'b0);
            1: add_item(nfcs_pkg::KIND_FBYTE, $urandom, $urandom, 8'($urandom), 1'b0);
            2: add_item(nfcs_pkg::KIND_HBYTE, $urandom, $urandom, 8'($urandom), 1'b0);
            default: add_item(nfcs_pkg::KIND_NONE, $urandom, $urandom, 8'($urandom), 1'b0);
          endcase
        end
      endcase
    end

    // Let everything drain, then allow the pipeline to settle.
    @(posedge rst_ni);
    do @(negedge clk_i); while (req_q.size() != 0 || in_valid_i);
    do @(negedge clk_i); while (n_seen != n_pred);
    repeat (20) @(negedge clk_i);
    if (n_errors == 0 && bus_words_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
